>>> hw/rtl/ezvad_pkg.sv
// shared constants, types and register codes of the voice activity detector
`default_nettype none
package ezvad_pkg;

  // frame and sample sizing
  localparam int SampleBits = 16;
  localparam int MaxFrame   = 4096;

  localparam int LenW   = $clog2(MaxFrame + 1);
  localparam int CrossW = $clog2(MaxFrame);
  localparam int MagW   = SampleBits;
  localparam int SqW    = 2 * SampleBits;
  localparam int SumW   = 2 * SampleBits - 2 + LenW;

  // configuration register widths
  localparam int EnergyW = 15;
  localparam int ZcrW    = 16;
  localparam int RunW    = 8;
  localparam int CfgIdxW = 8;
  localparam int CfgDatW = 16;

  // derived arithmetic widths
  localparam int T2W  = 2 * EnergyW;
  localparam int EpW  = T2W + LenW;
  localparam int ZpW  = ZcrW + LenW;
  localparam int CmpW = 64;

  // alignment of sample scale 2^(2B-2) to threshold scale 2^30
  localparam int EShL = (SampleBits <= 16) ? (32 - 2 * SampleBits) : 0;
  localparam int EShR = (SampleBits > 16) ? (2 * SampleBits - 32) : 0;

  // queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegEnergy     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegZcr        = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegMinSpeech  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegMinSilence = CfgIdxW'(3);

  // register reset values
  localparam logic [EnergyW-1:0] EnergyRst     = EnergyW'(328);
  localparam logic [ZcrW-1:0]    ZcrRst        = ZcrW'(19661);
  localparam logic [RunW-1:0]    MinSpeechRst  = RunW'(3);
  localparam logic [RunW-1:0]    MinSilenceRst = RunW'(10);

  localparam logic [RunW-1:0] RunMax = {RunW{1'b1}};

  typedef struct packed {
    logic [EnergyW-1:0] energy;
    logic [ZcrW-1:0]    zcr;
    logic [RunW-1:0]    min_speech;
    logic [RunW-1:0]    min_silence;
  } cfg_t;

  // one classified sample as it sits in the queue
  typedef struct packed {
    logic [SqW-1:0] sq;
    logic           neg;
    logic           last;
  } entry_t;

  typedef enum logic [3:0] {
    ST_ACC = 4'b0001,
    ST_SQR = 4'b0010,
    ST_MUL = 4'b0100,
    ST_DEC = 4'b1000
  } back_state_e;

endpackage
`default_nettype wire

>>> hw/rtl/ezvad_front.sv
// front stage: takes samples, finds sign and square, hands them to the queue
`default_nettype none
module ezvad_front (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  signed [ezvad_pkg::SampleBits-1:0] sample_i,
  input  wire                                  last_in_frame_i,
  output logic                                 push_valid_o,
  input  wire                                  push_ready_i,
  output ezvad_pkg::entry_t                    push_entry_o
);

  logic                           valid_q, valid_d;
  ezvad_pkg::entry_t              entry_q;
  logic [ezvad_pkg::MagW-1:0]     raw;
  logic [ezvad_pkg::MagW-1:0]     mag;
  logic                           neg;
  logic                           accept;

  assign raw = sample_i;
  assign neg = raw[ezvad_pkg::MagW-1];
  // two's complement magnitude, most negative value maps to 2^(B-1)
  assign mag = neg ? (~raw + 1'b1) : raw;

  assign in_ready_o = !valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q.sq   <= ezvad_pkg::SqW'(mag) * ezvad_pkg::SqW'(mag);
      entry_q.neg  <= neg;
      entry_q.last <= last_in_frame_i;
    end
  end

  assign push_valid_o = valid_q;
  assign push_entry_o = entry_q;

endmodule
`default_nettype wire

>>> hw/rtl/ezvad_fifo.sv
// short queue of classified samples between front and back
`default_nettype none
module ezvad_fifo (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_valid_i,
  output logic               push_ready_o,
  input  ezvad_pkg::entry_t  push_entry_i,
  output logic               pop_valid_o,
  input  wire                pop_ready_i,
  output ezvad_pkg::entry_t  pop_entry_o
);

  ezvad_pkg::entry_t                mem_q [ezvad_pkg::QDepth];
  logic [ezvad_pkg::QPtrW-1:0]      wr_q, rd_q;
  logic [ezvad_pkg::QCntW-1:0]      cnt_q;
  logic                             do_push, do_pop;

  assign push_ready_o = (cnt_q != ezvad_pkg::QCntW'(ezvad_pkg::QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ezvad_back.sv
// back stage: frame accumulation, frame-end decision and run tracking
`default_nettype none
module ezvad_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  ezvad_pkg::cfg_t    cfg_i,
  input  wire                pop_valid_i,
  output logic               pop_ready_o,
  input  ezvad_pkg::entry_t  pop_entry_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic               speech_active_o,
  output logic               frame_voiced_o
);

  ezvad_pkg::back_state_e            state_q, state_d;
  logic [ezvad_pkg::SumW-1:0]        sum_q, sum_d;
  logic [ezvad_pkg::LenW-1:0]        len_q, len_d;
  logic [ezvad_pkg::CrossW-1:0]      cross_q, cross_d;
  logic                              prev_neg_q, prev_neg_d;
  logic [ezvad_pkg::RunW-1:0]        vrun_q, vrun_d;
  logic [ezvad_pkg::RunW-1:0]        urun_q, urun_d;
  logic                              speak_q, speak_d;
  logic                              out_valid_q, out_valid_d;
  logic                              voiced_q, voiced_d;
  logic [ezvad_pkg::T2W-1:0]         t2_q;
  logic [ezvad_pkg::ZpW-1:0]         zp_q;
  logic [ezvad_pkg::EpW-1:0]         ep_q;
  logic [ezvad_pkg::CmpW-1:0]        e_lhs, e_rhs;
  logic [ezvad_pkg::ZpW-1:0]         z_lhs;
  logic                              voiced;
  logic                              do_pop;
  logic                              slot_free;

  assign pop_ready_o = (state_q == ezvad_pkg::ST_ACC);
  assign do_pop      = pop_valid_i && pop_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;

  assign e_lhs  = ezvad_pkg::CmpW'(sum_q) << ezvad_pkg::EShL;
  assign e_rhs  = ezvad_pkg::CmpW'(ep_q) << ezvad_pkg::EShR;
  assign z_lhs  = ezvad_pkg::ZpW'({cross_q, 16'b0});
  assign voiced = (e_lhs > e_rhs) && (z_lhs < zp_q);

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    len_d       = len_q;
    cross_d     = cross_q;
    prev_neg_d  = prev_neg_q;
    vrun_d      = vrun_q;
    urun_d      = urun_q;
    speak_d     = speak_q;
    out_valid_d = out_valid_q && !out_ready_i;
    voiced_d    = voiced_q;
    case (state_q)
      ezvad_pkg::ST_ACC: begin
        if (do_pop) begin
          // samples past the frame limit are dropped
          if (len_q < ezvad_pkg::LenW'(ezvad_pkg::MaxFrame)) begin
            sum_d = sum_q + ezvad_pkg::SumW'(pop_entry_i.sq);
            if ((len_q != '0) && (pop_entry_i.neg != prev_neg_q)) begin
              cross_d = cross_q + 1'b1;
            end
            prev_neg_d = pop_entry_i.neg;
            len_d      = len_q + 1'b1;
          end
          if (pop_entry_i.last) begin
            state_d = ezvad_pkg::ST_SQR;
          end
        end
      end
      ezvad_pkg::ST_SQR: begin
        state_d = ezvad_pkg::ST_MUL;
      end
      ezvad_pkg::ST_MUL: begin
        state_d = ezvad_pkg::ST_DEC;
      end
      ezvad_pkg::ST_DEC: begin
        if (slot_free) begin
          if (voiced) begin
            vrun_d = (vrun_q != ezvad_pkg::RunMax) ? vrun_q + 1'b1 : vrun_q;
            urun_d = '0;
            if (vrun_d >= cfg_i.min_speech) begin
              speak_d = 1'b1;
            end
          end else begin
            urun_d = (urun_q != ezvad_pkg::RunMax) ? urun_q + 1'b1 : urun_q;
            vrun_d = '0;
            if (urun_d >= cfg_i.min_silence) begin
              speak_d = 1'b0;
            end
          end
          voiced_d    = voiced;
          out_valid_d = 1'b1;
          sum_d       = '0;
          len_d       = '0;
          cross_d     = '0;
          prev_neg_d  = 1'b0;
          state_d     = ezvad_pkg::ST_ACC;
        end
      end
      default: begin
        state_d = ezvad_pkg::ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ezvad_pkg::ST_ACC;
      sum_q       <= '0;
      len_q       <= '0;
      cross_q     <= '0;
      prev_neg_q  <= 1'b0;
      vrun_q      <= '0;
      urun_q      <= '0;
      speak_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      len_q       <= len_d;
      cross_q     <= cross_d;
      prev_neg_q  <= prev_neg_d;
      vrun_q      <= vrun_d;
      urun_q      <= urun_d;
      speak_q     <= speak_d;
      out_valid_q <= out_valid_d;
    end
  end

  // threshold products, registered in the square and multiply steps
  always_ff @(posedge clk_i) begin
    voiced_q <= voiced_d;
    if (state_q == ezvad_pkg::ST_SQR) begin
      t2_q <= ezvad_pkg::T2W'(cfg_i.energy) * ezvad_pkg::T2W'(cfg_i.energy);
      zp_q <= ezvad_pkg::ZpW'(cfg_i.zcr) * ezvad_pkg::ZpW'(len_q);
    end
    if (state_q == ezvad_pkg::ST_MUL) begin
      ep_q <= ezvad_pkg::EpW'(t2_q) * ezvad_pkg::EpW'(len_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign speech_active_o = speak_q;
  assign frame_voiced_o  = voiced_q;

endmodule
`default_nettype wire

>>> hw/rtl/energy_zcr_voice_activity_detector.sv
// top level of the energy and zero-crossing voice activity detector
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   sample_i, last_in_frame_i
//   out      output     out_valid_o / out_ready_i speech_active_o, frame_voiced_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one sample word per cycle is taken while the four-deep queue has room; the back
// accumulates one queued word per cycle
// a word with the last flag takes the back through threshold square, threshold times
// length, compare and run update before the next frame's words drain
// a result word leaves the output register, the back holds its decision while it is full
// reset clears all frame sums, runs and the speaking flag; registers load their defaults
// cfg words are always taken and land in the cycle after the handshake
`default_nettype none
module energy_zcr_voice_activity_detector (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     in_valid_i,
  output logic                                    in_ready_o,
  input  wire  signed [ezvad_pkg::SampleBits-1:0] sample_i,
  input  wire                                     last_in_frame_i,
  output logic                                    out_valid_o,
  input  wire                                     out_ready_i,
  output logic                                    speech_active_o,
  output logic                                    frame_voiced_o,
  input  wire                                     cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire  [ezvad_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  wire  [ezvad_pkg::CfgDatW-1:0]           cfg_data_i
);

  ezvad_pkg::cfg_t   cfg_q;
  logic              push_valid, push_ready;
  ezvad_pkg::entry_t push_entry;
  logic              pop_valid, pop_ready;
  ezvad_pkg::entry_t pop_entry;

  // configuration registers, upper data bits beyond a register width are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.energy      <= ezvad_pkg::EnergyRst;
      cfg_q.zcr         <= ezvad_pkg::ZcrRst;
      cfg_q.min_speech  <= ezvad_pkg::MinSpeechRst;
      cfg_q.min_silence <= ezvad_pkg::MinSilenceRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ezvad_pkg::RegEnergy: begin
          cfg_q.energy <= cfg_data_i[ezvad_pkg::EnergyW-1:0];
        end
        ezvad_pkg::RegZcr: begin
          cfg_q.zcr <= cfg_data_i[ezvad_pkg::ZcrW-1:0];
        end
        ezvad_pkg::RegMinSpeech: begin
          cfg_q.min_speech <= cfg_data_i[ezvad_pkg::RunW-1:0];
        end
        ezvad_pkg::RegMinSilence: begin
          cfg_q.min_silence <= cfg_data_i[ezvad_pkg::RunW-1:0];
        end
        default: begin
          // unknown index, nothing written
        end
      endcase
    end
  end

  // front: sign and square of each sample
  ezvad_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .last_in_frame_i (last_in_frame_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_entry_o    (push_entry)
  );

  // queue decouples intake from the frame-end decision cycles
  ezvad_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // back: sums, crossing count, decision and speech runs
  ezvad_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_entry_i     (pop_entry),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .speech_active_o (speech_active_o),
    .frame_voiced_o  (frame_voiced_o)
  );

endmodule
`default_nettype wire

>>> tb/energy_zcr_voice_activity_detector_tb.sv
// self-checking testbench of the energy and zero-crossing voice activity detector
module energy_zcr_voice_activity_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ezvad_pkg::*;

  localparam int ClkPeriod    = 8;
  localparam int SettleCycles = 24;     // well past queue depth plus the decision cycles
  localparam int LongHold     = 80;     // long output hold-off, fills the sample queue
  localparam int PcmMax       = 2 ** (SampleBits - 1) - 1;
  localparam int PhaseWords   = 30;     // random words per register setting, at least
  localparam int SatFrames    = 260;    // enough to pin both run counters at their ceiling
  localparam int MaxReports   = 100;

  // index that maps to no register, writes there must change nothing
  localparam logic [CfgIdxW-1:0] RegNone = {CfgIdxW{1'b1}};

  // one sample word waiting for the driver
  typedef struct packed {
    logic signed [SampleBits-1:0] pcm;
    logic                         last;
  } pcm_word_t;

  // what the block should report when a frame closes
  typedef struct packed {
    logic speech;
    logic voiced;
  } verdict_t;

  // dut ports, every input known from time zero
  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         in_valid_i      = 1'b0;
  logic                         in_ready_o;
  logic signed [SampleBits-1:0] sample_i        = '0;
  logic                         last_in_frame_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i     = 1'b0;
  logic                         speech_active_o;
  logic                         frame_voiced_o;
  logic                         cfg_valid_i     = 1'b0;
  logic                         cfg_ready_o;
  logic [CfgIdxW-1:0]           cfg_index_i     = '0;
  logic [CfgDatW-1:0]           cfg_data_i      = '0;

  // stimulus and scoreboard
  pcm_word_t pcm_q[$];
  verdict_t  verdict_q[$];
  int        pushed_cnt  = 0;
  int        taken_cnt   = 0;
  int        errors      = 0;
  bit        no_idle     = 1'b0;
  bit        in_took     = 1'b0;
  bit        cfg_took    = 1'b0;
  int        gap_left    = 0;
  int        hold_left   = 0;
  int        hold_asked  = 0;
  int        hold_served = 0;

  // shadow of the register file, loaded with the reset values
  logic [EnergyW-1:0] thr_energy  = EnergyRst;
  logic [ZcrW-1:0]    thr_zcr     = ZcrRst;
  logic [RunW-1:0]    min_speech  = MinSpeechRst;
  logic [RunW-1:0]    min_silence = MinSilenceRst;

  // shadow of the frame accumulators and the run state
  longint unsigned sq_sum      = 0;
  int              frame_len   = 0;
  int              cross_cnt   = 0;
  logic            prev_neg    = 1'b0;
  logic [RunW-1:0] voiced_run  = '0;
  logic [RunW-1:0] quiet_run   = '0;
  logic            speaking    = 1'b0;

  // coverage tallies for the closing summary
  int frames_judged = 0;
  int frames_voiced = 0;
  int speech_flips  = 0;
  int reg_writes    = 0;
  int setups        = 0;

  energy_zcr_voice_activity_detector u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .last_in_frame_i (last_in_frame_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .speech_active_o (speech_active_o),
    .frame_voiced_o  (frame_voiced_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // one line per mismatch up to MaxReports, the count decides the verdict
  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MaxReports) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
  endtask

  // register write as the block sees it, upper data bits beyond the width drop
  task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    case (idx)
      RegEnergy:     thr_energy  = data[EnergyW-1:0];
      RegZcr:        thr_zcr     = data[ZcrW-1:0];
      RegMinSpeech:  min_speech  = data[RunW-1:0];
      RegMinSilence: min_silence = data[RunW-1:0];
      default: ;
    endcase
  endtask

  // fold one accepted word into the frame, judge the frame when the last flag comes
  task automatic judge_sample(input logic signed [SampleBits-1:0] pcm, input logic last);
    int              s;
    int              mag;
    logic            neg;
    logic            voiced;
    logic            was_speaking;
    longint unsigned energy_floor;
    longint unsigned zcr_bound;
    verdict_t        v;
    s = pcm;
    // words past the frame capacity are dropped, not squared and not compared
    if (frame_len < MaxFrame) begin
      neg = (s < 0);
      mag = neg ? -s : s;
      sq_sum += longint'(mag) * longint'(mag);
      if (frame_len != 0 && neg != prev_neg) begin
        cross_cnt++;
      end
      prev_neg = neg;
      frame_len++;
    end
    if (last) begin
      // sum > t^2 * n is rms > t without a root; sample scale lined up with q1.15
      energy_floor = longint'(thr_energy) * longint'(thr_energy) * longint'(frame_len);
      zcr_bound    = longint'(thr_zcr) * longint'(frame_len);
      voiced = ((sq_sum << EShL) > (energy_floor << EShR)) &&
               ((longint'(cross_cnt) << 16) < zcr_bound);
      was_speaking = speaking;
      if (voiced) begin
        if (voiced_run != RunMax) voiced_run++;
        quiet_run = '0;
        if (voiced_run >= min_speech) speaking = 1'b1;
      end else begin
        if (quiet_run != RunMax) quiet_run++;
        voiced_run = '0;
        if (quiet_run >= min_silence) speaking = 1'b0;
      end
      sq_sum    = 0;
      frame_len = 0;
      cross_cnt = 0;
      prev_neg  = 1'b0;
      v.speech = speaking;
      v.voiced = voiced;
      verdict_q.push_back(v);
      frames_judged++;
      if (voiced) frames_voiced++;
      if (speaking != was_speaking) speech_flips++;
    end
  endtask

  // sampling side: handshakes, prediction and the result check, all at the rising edge
  always @(posedge clk_i) begin
    verdict_t want;
    in_took  <= in_valid_i && in_ready_o;
    cfg_took <= cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        judge_sample(sample_i, last_in_frame_i);
        taken_cnt++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        apply_reg(cfg_index_i, cfg_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result word with no frame waiting for it");
        end else begin
          want = verdict_q.pop_front();
          if (speech_active_o !== want.speech) begin
            report_mismatch($sformatf("speech_active got %b want %b (frame %0d)",
                            speech_active_o, want.speech, frames_judged - verdict_q.size()));
          end
          if (frame_voiced_o !== want.voiced) begin
            report_mismatch($sformatf("frame_voiced got %b want %b (frame %0d)",
                            frame_voiced_o, want.voiced, frames_judged - verdict_q.size()));
          end
        end
      end
    end
  end

  // sample driver: holds a word until taken, then either idles a burst or offers the next one
  always @(negedge clk_i) begin
    pcm_word_t w;
    if (!in_valid_i || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (!no_idle && pcm_q.size() != 0 && $urandom_range(0, 99) < 10) begin
        gap_left = $urandom_range(0, 6);
        in_valid_i <= 1'b0;
      end else if (pcm_q.size() != 0) begin
        w = pcm_q.pop_front();
        sample_i        <= w.pcm;
        last_in_frame_i <= w.last;
        in_valid_i      <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver: short random stalls, plus the long hold-off when one is asked for
  always @(negedge clk_i) begin
    if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left = LongHold;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 12) begin
      hold_left = $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic push_word(input int v, input bit last);
    pcm_word_t w;
    w.pcm  = v[SampleBits-1:0];
    w.last = last;
    pcm_q.push_back(w);
    pushed_cnt++;
  endtask

  // frame with magnitudes up to amp; the sign flips with the given percent per word
  task automatic push_frame(input int len, input int amp, input int flip_pct);
    bit neg;
    int mag;
    int v;
    neg = $urandom_range(0, 1);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < flip_pct) neg = !neg;
      mag = $urandom_range(0, amp);
      v = neg ? -mag : mag;
      if (v > PcmMax) v = PcmMax;
      push_word(v, k == len - 1);
    end
  endtask

  // run of frames of one character, so that voiced and unvoiced runs build up
  task automatic push_burst();
    int frames;
    int kind;
    int len;
    int pick;
    frames = $urandom_range(1, 10);
    kind   = $urandom_range(0, 9);
    repeat (frames) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)      len = $urandom_range(1, 12);
      else if (pick < 95) len = $urandom_range(13, 64);
      else                len = $urandom_range(65, 160);
      if (kind < 4) begin
        // loud and tonal, mostly voiced
        push_frame(len, $urandom_range(4000, PcmMax + 1), 5);
      end else if (kind < 7) begin
        // near the energy threshold or below it
        push_frame(len, $urandom_range(0, 600), $urandom_range(0, 30));
      end else if (kind < 9) begin
        // hiss, many sign changes
        push_frame(len, $urandom_range(0, PcmMax + 1), $urandom_range(40, 100));
      end else begin
        // raw noise over the whole word width
        for (int k = 0; k < len; k++) begin
          push_word($urandom, k == len - 1);
        end
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!cfg_took);
    cfg_valid_i <= 1'b0;
    reg_writes++;
  endtask

  task automatic load_setup(input logic [CfgDatW-1:0] energy, input logic [CfgDatW-1:0] zcr,
                            input logic [CfgDatW-1:0] speech_min,
                            input logic [CfgDatW-1:0] silence_min);
    write_reg(RegEnergy, energy);
    write_reg(RegZcr, zcr);
    write_reg(RegMinSpeech, speech_min);
    write_reg(RegMinSilence, silence_min);
    setups++;
  endtask

  // block idle: every word taken, every verdict out, and the back end given time to finish
  task automatic drain();
    while (taken_cnt != pushed_cnt || verdict_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // generous ceiling, several times the slowest legal run
  initial begin
    #(ClkPeriod * 1_000_000);
    $display("timeout with %0d words taken of %0d, %0d verdicts outstanding",
             taken_cnt, pushed_cnt, verdict_q.size());
    $display("energy_zcr_voice_activity_detector_tb: FAIL");
    $finish;
  end

  initial begin
    int e;
    int z;
    int ms;
    int ml;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed frames under the reset register values
    push_word(PcmMax, 1'b1);                          // single word frame, full scale
    push_word(-PcmMax - 1, 1'b0);                     // most negative code, no crossing
    push_word(-PcmMax - 1, 1'b1);
    push_word(0, 1'b1);                               // silent frame, zero energy
    push_word(1000, 1'b0);                            // sign change on every word
    push_word(-1000, 1'b0);
    push_word(1000, 1'b0);
    push_word(-1000, 1'b0);
    push_word(1000, 1'b0);
    push_word(-1000, 1'b1);
    push_word(-1, 1'b0);                              // tiny values around zero
    push_word(1, 1'b0);
    push_word(0, 1'b0);
    push_word(-1, 1'b1);
    push_word(20000, 1'b0);                           // three voiced frames set speech
    push_word(20000, 1'b1);
    push_word(-20000, 1'b0);
    push_word(-20000, 1'b1);
    push_word(PcmMax, 1'b1);
    push_word(-1, 1'b1);                              // new frame starts negative
    drain();

    // lowest energy threshold, widest zero crossing limit, minimums of one
    load_setup(16'd0, 16'hFFFF, 16'd1, 16'd1);
    repeat (2) push_burst();
    drain();

    // highest energy threshold through a write with the spare top bit set, zero crossing limit
    load_setup(16'hFFFF, 16'd0, 16'd255, 16'd255);
    write_reg(RegNone, 16'h0000);
    write_reg(RegMinSilence + 1'b1, 16'hFFFF);
    push_frame(8, PcmMax + 1, 0);
    repeat (1) push_burst();
    drain();

    // zero minimums, the first frame alone moves the speech flag
    load_setup(16'd300, 16'd30000, 16'd0, 16'd0);
    repeat (2) push_burst();
    drain();

    // run counters driven into saturation in both directions
    load_setup(16'd0, 16'hFFFF, 16'd255, 16'd255);
    repeat (SatFrames) push_word(($urandom_range(0, 1) ? -1 : 1) * $urandom_range(1, PcmMax),
                                 1'b1);
    repeat (SatFrames) push_word(0, 1'b1);
    drain();

    // random settings with bursty frame content
    for (int ph = 0; ph < 5; ph++) begin
      e  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PcmMax) : $urandom_range(0, 3000);
      z  = $urandom_range(0, 65535);
      ms = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6);
      ml = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6);
      load_setup({1'($urandom_range(0, 1)), 15'(e)}, 16'(z),
                 {8'($urandom), 8'(ms)}, {8'($urandom), 8'(ml)});
      // last setting runs with no idling on either side
      if (ph == 4) no_idle = 1'b1;
      if (ph == 1) begin
        // receiver holds off while short frames keep coming, the queue backs up
        repeat (30) push_frame(1, PcmMax + 1, 0);
        hold_asked++;
      end
      e = pushed_cnt + PhaseWords;
      while (pushed_cnt < e) push_burst();
      // sender waits for every verdict before the next setting
      drain();
    end

    drain();
    $display("%0d sample words in %0d frames, %0d voiced, speech flag changed %0d times",
             taken_cnt, frames_judged, frames_voiced, speech_flips);
    $display("%0d register writes over %0d settings, %0d long output hold-offs",
             reg_writes, setups, hold_asked);
    if (errors == 0) begin
      $display("energy_zcr_voice_activity_detector_tb: PASS");
    end else begin
      $display("energy_zcr_voice_activity_detector_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> energy_zcr_voice_activity_detector.f
hw/rtl/ezvad_pkg.sv
hw/rtl/ezvad_front.sv
hw/rtl/ezvad_fifo.sv
hw/rtl/ezvad_back.sv
hw/rtl/energy_zcr_voice_activity_detector.sv
tb/energy_zcr_voice_activity_detector_tb.sv
